FILE: hw/rtl/sfaai_pkg.sv
// ============================================================================
// sfaai_pkg: shared types and constants of the flash auto-increment sequencer
// Frame descriptor, opcode group, register indexes and sizing constants.
// ============================================================================
`default_nettype none

package sfaai_pkg;

  localparam int BYTE_W            = 8;
  localparam int SPI_ADDR_W        = 24;  // address bits carried in a frame
  localparam int ADDR_BITS_DEFAULT = 24;
  localparam int ADDR_BITS_MAX     = 32;
  localparam int CFG_IDX_W         = 8;
  localparam int QUEUE_DEPTH       = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_ENABLE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_DISABLE  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_PROGRAM   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_INCREMENT = 8'd3;

  // Opcode reset values
  localparam logic [BYTE_W-1:0] RST_WRITE_ENABLE   = 8'h06;
  localparam logic [BYTE_W-1:0] RST_WRITE_DISABLE  = 8'h04;
  localparam logic [BYTE_W-1:0] RST_BYTE_PROGRAM   = 8'h02;
  localparam logic [BYTE_W-1:0] RST_AUTO_INCREMENT = 8'hAD;

  // Middle action of a request
  localparam logic [1:0] MID_NONE   = 2'd0;
  localparam logic [1:0] MID_SINGLE = 2'd1;
  localparam logic [1:0] MID_START  = 2'd2;
  localparam logic [1:0] MID_CONT   = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] write_enable;
    logic [BYTE_W-1:0] write_disable;
    logic [BYTE_W-1:0] byte_program;
    logic [BYTE_W-1:0] auto_increment;
  } opcodes_t;

  // Everything the back end needs to expand one request into SPI bytes
  typedef struct packed {
    logic                  close_pre;   // write-disable before anything else
    logic [1:0]            mid;         // single, start pair or continue pair
    logic                  close_post;  // write-disable at end of run
    logic                  tail;        // leftover byte programmed alone
    logic [SPI_ADDR_W-1:0] addr;        // address of single/start/tail frame
    logic [BYTE_W-1:0]     byte_a;      // first byte of a pair
    logic [BYTE_W-1:0]     byte_b;      // current byte (second of pair/single)
  } desc_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sfaai_in_if.sv
// ============================================================================
// sfaai_in_if: input request channel
// One byte to program, with run markers and start address.
// ============================================================================
`default_nettype none

interface sfaai_in_if import sfaai_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SPI_ADDR_W-1:0] start_address;
  logic [BYTE_W-1:0]     data_byte;
  logic                  first_of_run;
  logic                  last_of_run;

  modport source (output valid, start_address, data_byte, first_of_run, last_of_run,
                  input ready);
  modport sink   (input valid, start_address, data_byte, first_of_run, last_of_run,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sfaai_out_if.sv
// ============================================================================
// sfaai_out_if: SPI byte result channel
// One serial byte with frame and busy-poll markers.
// ============================================================================
`default_nettype none

interface sfaai_out_if import sfaai_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] spi_byte;
  logic              end_of_frame;
  logic              poll_busy_after;
  logic              last_result;

  modport source (output valid, spi_byte, end_of_frame, poll_busy_after, last_result,
                  input ready);
  modport sink   (input valid, spi_byte, end_of_frame, poll_busy_after, last_result,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sfaai_cfg_if.sv
// ============================================================================
// sfaai_cfg_if: configuration write channel
// Register index plus write data.
// ============================================================================
`default_nettype none

interface sfaai_cfg_if import sfaai_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [BYTE_W-1:0]    wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/spi_flash_aai_write_sequencer.sv
// ============================================================================
// spi_flash_aai_write_sequencer: serial flash auto-increment program sequencer
// Turns a run of bytes into write-enable, program and auto-increment frames.
// ============================================================================
// Each input request carries one byte to program; the first request of a run
// also carries the 24-bit start address. The block answers with the SPI bytes
// the host shifts out, one result per byte, with end_of_frame marking chip
// deselect, poll_busy_after marking frames after which the host polls the
// busy status, and last_result marking the final byte caused by a request.
// A byte at an odd address with no pair pending is programmed alone; later
// bytes go out in pairs, the first pair as an auto-increment start frame and
// further pairs as short continuation frames; the run end sends write-disable
// and programs any leftover byte alone. A request produces between zero and
// eight bytes. The front end takes one request per cycle while its two-entry
// descriptor queue has room; the back end drives one byte per cycle through a
// registered output while the host accepts them, so the output byte rate sets
// the pace. Configuration writes are always accepted and take effect on the
// next byte.
// ============================================================================
`default_nettype none

module spi_flash_aai_write_sequencer import sfaai_pkg::*; #(
  parameter int ADDRESS_BITS = ADDR_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  sfaai_in_if.sink    in_ch,
  sfaai_out_if.source out_ch,
  sfaai_cfg_if.sink   cfg_ch
);

  localparam int DescW = $bits(desc_t);

  // Opcode registers
  opcodes_t opc_r, opc_nxt;

  logic     q_push, q_pop, q_full, q_empty;
  desc_t    front_desc;
  desc_t    back_desc;

  assign cfg_ch.ready = 1'b1;

  // Decode the register index; drop writes beyond the list
  always_comb begin
    opc_nxt = opc_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_WRITE_ENABLE:   opc_nxt.write_enable   = cfg_ch.wdata;
        REG_WRITE_DISABLE:  opc_nxt.write_disable  = cfg_ch.wdata;
        REG_BYTE_PROGRAM:   opc_nxt.byte_program   = cfg_ch.wdata;
        REG_AUTO_INCREMENT: opc_nxt.auto_increment = cfg_ch.wdata;
        default:            opc_nxt                = opc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opc_r.write_enable   <= RST_WRITE_ENABLE;
      opc_r.write_disable  <= RST_WRITE_DISABLE;
      opc_r.byte_program   <= RST_BYTE_PROGRAM;
      opc_r.auto_increment <= RST_AUTO_INCREMENT;
    end else begin
      opc_r <= opc_nxt;
    end
  end

  // Front end: classify requests, track address and pairing
  sfaai_front #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_desc (front_desc)
  );

  // Descriptor queue: lets the front keep accepting while bytes drain
  sfaai_fifo #(
    .WIDTH (DescW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (front_desc),
    .pop     (q_pop),
    .rd_data (back_desc),
    .full    (q_full),
    .empty   (q_empty)
  );

  // Back end: expand descriptors into SPI bytes
  sfaai_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .opc     (opc_r),
    .q_empty (q_empty),
    .q_desc  (back_desc),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/sfaai_fifo.sv
// ============================================================================
// sfaai_fifo: small register queue
// Holds frame descriptors between the front and back ends.
// ============================================================================
`default_nettype none

module sfaai_fifo import sfaai_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sfaai_front.sv
// ============================================================================
// sfaai_front: request classifier
// Tracks run address and pairing state, emits a frame descriptor per request that yields bytes.
// ============================================================================
`default_nettype none

module sfaai_front import sfaai_pkg::*; #(
  parameter int ADDRESS_BITS = ADDR_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst_n,
  sfaai_in_if.sink   in_ch,
  input  logic       q_full,
  output logic       q_push,
  output desc_t      q_desc
);

  logic [ADDRESS_BITS-1:0] addr_r, addr_nxt;
  logic [BYTE_W-1:0]       held_byte_r, held_byte_nxt;
  logic                    held_r, held_nxt;
  logic                    inc_r, inc_nxt;

  logic                     accept;
  logic                     first, last;
  logic                     held_eff, inc_eff;
  logic [BYTE_W-1:0]        held_byte_eff;
  logic [ADDRESS_BITS-1:0]  addr_eff;
  logic [ADDR_BITS_MAX-1:0] addr_ext;
  desc_t                    desc;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign first       = in_ch.first_of_run;
  assign last        = in_ch.last_of_run;

  always_comb begin
    // A run start drops whatever the old run left open
    held_eff      = held_r && !first;
    inc_eff       = inc_r && !first;
    held_byte_eff = first ? '0 : held_byte_r;
    addr_eff      = first ? ADDRESS_BITS'(in_ch.start_address) : addr_r;
    addr_ext      = ADDR_BITS_MAX'(addr_eff);

    desc.close_pre  = first && inc_r;
    desc.mid        = MID_NONE;
    desc.close_post = 1'b0;
    desc.tail       = 1'b0;
    desc.addr       = addr_ext[SPI_ADDR_W-1:0];
    desc.byte_a     = held_byte_eff;
    desc.byte_b     = in_ch.data_byte;

    addr_nxt      = addr_eff;
    held_byte_nxt = held_byte_eff;
    held_nxt      = held_eff;
    inc_nxt       = inc_eff;

    if (!held_eff && !inc_eff && addr_eff[0]) begin
      // odd address, nothing open: program alone
      desc.mid = MID_SINGLE;
      addr_nxt = addr_eff + ADDRESS_BITS'(1);
    end else if (!held_eff) begin
      held_byte_nxt = in_ch.data_byte;
      held_nxt      = 1'b1;
    end else begin
      desc.mid = inc_eff ? MID_CONT : MID_START;
      inc_nxt  = 1'b1;
      held_nxt = 1'b0;
      addr_nxt = addr_eff + ADDRESS_BITS'(2);
    end

    if (last) begin
      desc.close_post = inc_nxt;
      inc_nxt         = 1'b0;
      if (held_nxt) begin
        // held byte is the current one, at the unchanged address
        desc.tail = 1'b1;
        held_nxt  = 1'b0;
        addr_nxt  = addr_nxt + ADDRESS_BITS'(1);
      end
    end
  end

  assign q_desc = desc;
  assign q_push = accept &&
                  (desc.close_pre || (desc.mid != MID_NONE) || desc.close_post || desc.tail);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      held_byte_r <= '0;
      held_r      <= 1'b0;
      inc_r       <= 1'b0;
    end else if (accept) begin
      addr_r      <= addr_nxt;
      held_byte_r <= held_byte_nxt;
      held_r      <= held_nxt;
      inc_r       <= inc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sfaai_back.sv
// ============================================================================
// sfaai_back: frame expander
// Walks a descriptor segment by segment and drives one SPI byte per cycle while the host takes them.
// ============================================================================
`default_nettype none

module sfaai_back import sfaai_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  opcodes_t    opc,
  input  logic        q_empty,
  input  desc_t       q_desc,
  output logic        q_pop,
  sfaai_out_if.source out_ch
);

  // Segment kinds; pair and single kinds share the descriptor's mid codes
  localparam logic [1:0] SEG_WRDI   = MID_NONE;
  localparam logic [1:0] SEG_SINGLE = MID_SINGLE;
  localparam logic [1:0] SEG_START  = MID_START;
  localparam logic [1:0] SEG_CONT   = MID_CONT;

  localparam logic [2:0] LAST_WRDI   = 3'd0;
  localparam logic [2:0] LAST_SINGLE = 3'd5;
  localparam logic [2:0] LAST_START  = 3'd6;
  localparam logic [2:0] LAST_CONT   = 3'd2;

  logic                  pre_r, pre_nxt;
  logic [1:0]            mid_r, mid_nxt;
  logic                  post_r, post_nxt;
  logic                  tail_r, tail_nxt;
  logic [2:0]            idx_r, idx_nxt;
  logic [SPI_ADDR_W-1:0] addr_r, addr_nxt;
  logic [BYTE_W-1:0]     a_r, a_nxt;
  logic [BYTE_W-1:0]     b_r, b_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]     out_byte_r, out_byte_nxt;
  logic                  out_eof_r, out_eof_nxt;
  logic                  out_poll_r, out_poll_nxt;
  logic                  out_last_r, out_last_nxt;

  logic              advance, active, rest, seg_done, desc_done;
  logic [1:0]        seg;
  logic [2:0]        seg_last;
  logic [BYTE_W-1:0] gen_byte;
  logic              gen_eof, gen_poll;

  assign advance = !out_valid_r || out_ch.ready;
  assign active  = pre_r || (mid_r != MID_NONE) || post_r || tail_r;

  // Pick the current segment and whether anything follows it
  always_comb begin
    if (pre_r) begin
      seg  = SEG_WRDI;
      rest = (mid_r != MID_NONE) || post_r || tail_r;
    end else if (mid_r != MID_NONE) begin
      seg  = mid_r;
      rest = post_r || tail_r;
    end else if (post_r) begin
      seg  = SEG_WRDI;
      rest = tail_r;
    end else begin
      seg  = SEG_SINGLE;
      rest = 1'b0;
    end
    case (seg)
      SEG_WRDI:   seg_last = LAST_WRDI;
      SEG_SINGLE: seg_last = LAST_SINGLE;
      SEG_START:  seg_last = LAST_START;
      default:    seg_last = LAST_CONT;
    endcase
  end

  assign seg_done  = (idx_r == seg_last);
  assign desc_done = seg_done && !rest;

  // Byte generation per segment position
  always_comb begin
    gen_byte = b_r;
    gen_eof  = 1'b0;
    gen_poll = 1'b0;
    case (seg)
      SEG_WRDI: begin
        gen_byte = opc.write_disable;
        gen_eof  = 1'b1;
        gen_poll = 1'b1;
      end
      SEG_SINGLE, SEG_START: begin
        case (idx_r)
          3'd0: begin
            gen_byte = opc.write_enable;
            gen_eof  = 1'b1;
          end
          3'd1: gen_byte = (seg == SEG_SINGLE) ? opc.byte_program : opc.auto_increment;
          3'd2: gen_byte = addr_r[23:16];
          3'd3: gen_byte = addr_r[15:8];
          3'd4: gen_byte = addr_r[7:0];
          default: begin
            if (idx_r == seg_last) begin
              gen_byte = b_r;
              gen_eof  = 1'b1;
              gen_poll = 1'b1;
            end else begin
              gen_byte = a_r;
            end
          end
        endcase
      end
      default: begin
        case (idx_r)
          3'd0:    gen_byte = opc.auto_increment;
          3'd1:    gen_byte = a_r;
          default: begin
            gen_byte = b_r;
            gen_eof  = 1'b1;
            gen_poll = 1'b1;
          end
        endcase
      end
    endcase
  end

  always_comb begin
    pre_nxt       = pre_r;
    mid_nxt       = mid_r;
    post_nxt      = post_r;
    tail_nxt      = tail_r;
    idx_nxt       = idx_r;
    addr_nxt      = addr_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_eof_nxt   = out_eof_r;
    out_poll_nxt  = out_poll_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;

    if (advance) begin
      out_valid_nxt = active;
      if (active) begin
        out_byte_nxt = gen_byte;
        out_eof_nxt  = gen_eof;
        out_poll_nxt = gen_poll;
        out_last_nxt = desc_done;
        if (seg_done) begin
          idx_nxt = '0;
          if (pre_r) begin
            pre_nxt = 1'b0;
          end else if (mid_r != MID_NONE) begin
            mid_nxt = MID_NONE;
          end else if (post_r) begin
            post_nxt = 1'b0;
          end else begin
            tail_nxt = 1'b0;
          end
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      // load the next descriptor without a bubble
      if ((!active || desc_done) && !q_empty) begin
        q_pop    = 1'b1;
        pre_nxt  = q_desc.close_pre;
        mid_nxt  = q_desc.mid;
        post_nxt = q_desc.close_post;
        tail_nxt = q_desc.tail;
        idx_nxt  = '0;
        addr_nxt = q_desc.addr;
        a_nxt    = q_desc.byte_a;
        b_nxt    = q_desc.byte_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r       <= 1'b0;
      mid_r       <= MID_NONE;
      post_r      <= 1'b0;
      tail_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pre_r       <= pre_nxt;
      mid_r       <= mid_nxt;
      post_r      <= post_nxt;
      tail_r      <= tail_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    out_byte_r <= out_byte_nxt;
    out_eof_r  <= out_eof_nxt;
    out_poll_r <= out_poll_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.spi_byte        = out_byte_r;
  assign out_ch.end_of_frame    = out_eof_r;
  assign out_ch.poll_busy_after = out_poll_r;
  assign out_ch.last_result     = out_last_r;

endmodule

`default_nettype wire
